/* rtl/nnsa_pkg.sv */
// ----------------------------------------------------------------------------
// nnsa_pkg: shared constants, types and helpers
// Widths, register indexes, the reciprocal used for the divide by 100 and
// the payload type that moves through the divider pipeline.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int MAX_PERCENT = 6400;

   localparam int REG_W     = 13;                 // configuration register width
   localparam int DEST_W    = 18;                 // destination coordinate width
   localparam int SIZE_W    = 19;                 // destination size width
   localparam int SRC_W     = $clog2(MAX_DIM);    // source coordinate width
   localparam int IDX_W     = 2 * SRC_W;          // linear source index width
   localparam int REM_W     = 25;                 // dest * 100 fits here
   localparam int PROD_W    = 2 * REG_W;          // size * percent product
   localparam int CSR_IDX_W = 8;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 2;

   localparam int PCT_UNIT = 100;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^30
   localparam int          RECIP_SHIFT = 32;
   localparam int          RECIP_W     = 26;
   localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_PERCENT     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_PERCENT     = 8'd3;

   localparam logic [REG_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [REG_W-1:0] RESET_HEIGHT = 13'd480;

   // One item in flight through the divider: coordinates, partial
   // remainders and the quotient bits found so far, per axis.
   typedef struct packed {
      logic [DEST_W-1:0] dest_x;
      logic [DEST_W-1:0] dest_y;
      logic [REM_W-1:0]  rem_x;
      logic [REM_W-1:0]  rem_y;
      logic [SRC_W-1:0]  quo_x;
      logic [SRC_W-1:0]  quo_y;
   } div_stage_type;

   function automatic logic [REG_W-1:0] sat_reg(input logic [REG_W-1:0] value,
                                                input logic [REG_W-1:0] limit);
      return (value > limit) ? limit : value;
   endfunction

endpackage

/* rtl/nnsa_size.sv */
// ----------------------------------------------------------------------------
// nnsa_size: destination size of one axis
// Two register stages: size * percent, then divide by 100 through a
// reciprocal multiply. Zero percent passes the source size through.
// ----------------------------------------------------------------------------
module nnsa_size (
   input  logic                         clock,
   input  logic [nnsa_pkg::REG_W-1:0]   size,
   input  logic [nnsa_pkg::REG_W-1:0]   pct,
   output logic [nnsa_pkg::SIZE_W-1:0]  dest_size
);

   localparam int SCALED_W = nnsa_pkg::PROD_W + nnsa_pkg::RECIP_W;

   logic [nnsa_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [nnsa_pkg::SIZE_W-1:0] dest_ff, dest_in;
   logic [SCALED_W-1:0]         scaled;

   assign prod_in = {{nnsa_pkg::REG_W{1'b0}}, size} * {{nnsa_pkg::REG_W{1'b0}}, pct};

   assign scaled = {{nnsa_pkg::RECIP_W{1'b0}}, prod_ff}
                 * {{nnsa_pkg::PROD_W{1'b0}}, nnsa_pkg::RECIP_100};

   always_comb begin
      if (pct == '0) begin
         dest_in = nnsa_pkg::SIZE_W'(size);
      end else begin
         dest_in = scaled[nnsa_pkg::RECIP_SHIFT +: nnsa_pkg::SIZE_W];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dest_ff <= dest_in;
   end

   assign dest_size = dest_ff;

endmodule

/* rtl/nnsa_div_step.sv */
// ----------------------------------------------------------------------------
// nnsa_div_step: one restoring divide step for both axes
// Resolves quotient bit BIT of (dest * 100) / percent and registers the
// partial remainder for the next step.
// ----------------------------------------------------------------------------
module nnsa_div_step #(
   parameter int BIT = 0
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [nnsa_pkg::REG_W-1:0]    px,
   input  logic [nnsa_pkg::REG_W-1:0]    py,
   input  nnsa_pkg::div_stage_type       din,
   output nnsa_pkg::div_stage_type       dout
);

   nnsa_pkg::div_stage_type     stage_ff, stage_in;
   logic [nnsa_pkg::REM_W-1:0]  dvs_x, dvs_y;
   logic                        ge_x, ge_y;

   assign dvs_x = nnsa_pkg::REM_W'(px) << BIT;
   assign dvs_y = nnsa_pkg::REM_W'(py) << BIT;
   assign ge_x  = (din.rem_x >= dvs_x);
   assign ge_y  = (din.rem_y >= dvs_y);

   always_comb begin
      stage_in = din;
      stage_in.quo_x[BIT] = ge_x;
      stage_in.quo_y[BIT] = ge_y;
      if (ge_x) begin
         stage_in.rem_x = din.rem_x - dvs_x;
      end
      if (ge_y) begin
         stage_in.rem_y = din.rem_y - dvs_y;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign dout = stage_ff;

endmodule

/* rtl/nearest_neighbor_scale_address.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address: nearest-neighbor zoom address generator
// Maps a destination pixel to its source pixel for a per-axis percent zoom.
// ----------------------------------------------------------------------------
// One destination coordinate enters per clock and its source coordinate,
// linear source index, destination sizes and flags leave through the input
// register, twelve one-bit divider steps, a finishing stage with the row
// multiply and the output register; a new item is taken every cycle that the
// output register is empty or being taken. The twelve-step divider pipeline
// computes floor(dest * 100 / percent). Configuration writes are always ready;
// the derived destination sizes follow a write through the configuration
// register and the nnsa_size registers. A zero percent leaves an axis as is.
// Coordinates outside the destination image give zero source fields.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nnsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nnsa_pkg::REG_W-1:0]           csr_data,
   // destination coordinates
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [nnsa_pkg::REQ_TDATA_W-1:0]     req_tdata,   // dest_x, dest_y
   // source addresses
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // src_x, src_y, src_index, dest_width, dest_height
   output logic [nnsa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [nnsa_pkg::RSP_TUSER_W-1:0]     rsp_tuser    // inside_res, path_covered
);

   localparam int STEPS = nnsa_pkg::SRC_W;

   // ---------------------------------------------------------------- config
   logic [nnsa_pkg::REG_W-1:0] w_ff, h_ff, px_ff, py_ff;
   logic [nnsa_pkg::REG_W-1:0] w_in, h_in, px_in, py_in;
   logic [nnsa_pkg::REG_W-1:0] dim_sat, pct_sat;

   assign csr_ready = 1'b1;
   // Saturate on write so every downstream width holds.
   assign dim_sat = nnsa_pkg::sat_reg(csr_data, nnsa_pkg::REG_W'(nnsa_pkg::MAX_DIM));
   assign pct_sat = nnsa_pkg::sat_reg(csr_data, nnsa_pkg::REG_W'(nnsa_pkg::MAX_PERCENT));

   always_comb begin
      w_in  = w_ff;
      h_in  = h_ff;
      px_in = px_ff;
      py_in = py_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            nnsa_pkg::CSR_SOURCE_WIDTH:  w_in  = dim_sat;
            nnsa_pkg::CSR_SOURCE_HEIGHT: h_in  = dim_sat;
            nnsa_pkg::CSR_X_PERCENT:     px_in = pct_sat;
            nnsa_pkg::CSR_Y_PERCENT:     py_in = pct_sat;
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= nnsa_pkg::RESET_WIDTH;
         h_ff  <= nnsa_pkg::RESET_HEIGHT;
         px_ff <= '0;
         py_ff <= '0;
      end else begin
         w_ff  <= w_in;
         h_ff  <= h_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // Destination sizes follow the registers continuously.
   logic [nnsa_pkg::SIZE_W-1:0] dw, dh;

   nnsa_size u_size_x (.clock(clock), .size(w_ff), .pct(px_ff), .dest_size(dw));
   nnsa_size u_size_y (.clock(clock), .size(h_ff), .pct(py_ff), .dest_size(dh));

   // ------------------------------------------------------------- pipeline
   // All stages advance together whenever the output register can move.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [STEPS:0]           vld_ff, vld_in;
   nnsa_pkg::div_stage_type  s0_ff, s0_in;
   nnsa_pkg::div_stage_type  chain [0:STEPS];

   always_comb begin
      s0_in.dest_x = req_tdata[0 +: nnsa_pkg::DEST_W];
      s0_in.dest_y = req_tdata[nnsa_pkg::DEST_W +: nnsa_pkg::DEST_W];
      s0_in.rem_x  = nnsa_pkg::REM_W'(s0_in.dest_x) * nnsa_pkg::REM_W'(nnsa_pkg::PCT_UNIT);
      s0_in.rem_y  = nnsa_pkg::REM_W'(s0_in.dest_y) * nnsa_pkg::REM_W'(nnsa_pkg::PCT_UNIT);
      s0_in.quo_x  = '0;
      s0_in.quo_y  = '0;
   end

   assign vld_in = {vld_ff[STEPS-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   assign chain[0] = s0_ff;

   // Resolve quotient bits from the top down, one per stage.
   for (genvar g = 0; g < STEPS; g++) begin : g_div
      nnsa_div_step #(.BIT(STEPS - 1 - g)) u_step (
         .clock  (clock),
         .enable (adv),
         .px     (px_ff),
         .py     (py_ff),
         .din    (chain[g]),
         .dout   (chain[g+1])
      );
   end

   // ------------------------------------------------------------- finish
   nnsa_pkg::div_stage_type      last;
   logic                         fin_vld_ff;
   logic                         fin_inside_ff, fin_inside_in;
   logic [nnsa_pkg::SRC_W-1:0]   fin_sx_ff, fin_sx_in, fin_sy_ff, fin_sy_in;
   logic [nnsa_pkg::IDX_W-1:0]   fin_prod_ff, fin_prod_in;
   logic [nnsa_pkg::SRC_W+nnsa_pkg::REG_W-1:0] row_prod;

   assign last = chain[STEPS];

   always_comb begin
      fin_inside_in = (nnsa_pkg::SIZE_W'(last.dest_x) < dw)
                   && (nnsa_pkg::SIZE_W'(last.dest_y) < dh);
      fin_sx_in = (px_ff == '0) ? last.dest_x[nnsa_pkg::SRC_W-1:0] : last.quo_x;
      fin_sy_in = (py_ff == '0) ? last.dest_y[nnsa_pkg::SRC_W-1:0] : last.quo_y;
      // Zero the source fields outside the destination image.
      if (!fin_inside_in) begin
         fin_sx_in = '0;
         fin_sy_in = '0;
      end
   end

   assign row_prod    = {{nnsa_pkg::REG_W{1'b0}}, fin_sy_in}
                      * {{nnsa_pkg::SRC_W{1'b0}}, w_ff};
   assign fin_prod_in = row_prod[nnsa_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_inside_ff <= fin_inside_in;
         fin_sx_ff     <= fin_sx_in;
         fin_sy_ff     <= fin_sy_in;
         fin_prod_ff   <= fin_prod_in;
      end
   end

   // ------------------------------------------------------------- output
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nnsa_pkg::SRC_W-1:0]   rsp_sx_ff, rsp_sy_ff;
   logic [nnsa_pkg::IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                         rsp_inside_ff, rsp_path_ff, rsp_path_in;
   logic [nnsa_pkg::SIZE_W-1:0]  rsp_dw_ff, rsp_dh_ff;

   assign rsp_idx_in   = fin_prod_ff + nnsa_pkg::IDX_W'(fin_sx_ff);
   // Clear the flag for settings that belong to the separate downscale path.
   assign rsp_path_in  = !((px_ff < nnsa_pkg::REG_W'(nnsa_pkg::PCT_UNIT))
                        && (py_ff < nnsa_pkg::REG_W'(nnsa_pkg::PCT_UNIT))
                        && !((px_ff == '0) && (py_ff == '0)));
   assign rsp_valid_in = adv ? fin_vld_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fin_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff     <= vld_in;
            fin_vld_ff <= vld_ff[STEPS];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sx_ff     <= fin_sx_ff;
         rsp_sy_ff     <= fin_sy_ff;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_inside_ff <= fin_inside_ff;
         rsp_path_ff   <= rsp_path_in;
         rsp_dw_ff     <= dw;
         rsp_dh_ff     <= dh;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_dh_ff, rsp_dw_ff, rsp_idx_ff, rsp_sy_ff, rsp_sx_ff};
   assign rsp_tuser  = {rsp_path_ff, rsp_inside_ff};

   // ----------------------------------------------------------- assertions
   // A finished item moves into the output register when the pipe advances.
   a_fin_to_out: assert property (@(posedge clock) disable iff (reset)
      (fin_vld_ff && adv) |=> rsp_valid_ff)
      else $error("finished item lost before output register");

   // Outside coordinates carry zero source fields.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_inside_ff)
         |-> (rsp_sx_ff == '0 && rsp_sy_ff == '0 && rsp_idx_ff == '0))
      else $error("nonzero source fields for outside coordinate");

   // An inside coordinate maps into the source image.
   a_inside_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff)
         |-> (nnsa_pkg::REG_W'(rsp_sx_ff) < w_ff && nnsa_pkg::REG_W'(rsp_sy_ff) < h_ff))
      else $error("source coordinate beyond source image");

endmodule
